FILE: rtl/core/ibcs_pkg.sv
// ----------------------------------------------------------------------------
// ibcs_pkg
// Shared types and constants of the indirect-buffer call stack.
// ----------------------------------------------------------------------------
`default_nettype none

package ibcs_pkg;

  // Number of frames the call stack can hold.
  localparam int NEST_DEPTH = 4;

  // The depth counter must be able to hold NEST_DEPTH itself.
  localparam int DEPTH_W = $clog2(NEST_DEPTH + 1);
  // Index into the frame memory.
  localparam int ADDR_W  = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;

  typedef enum logic [1:0] {
    OP_SUBMIT  = 2'd0,
    OP_ADVANCE = 2'd1,
    OP_JUMP    = 2'd2,
    OP_RETURN  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FAULT    = 2'd1,
    STATUS_OVERFLOW = 2'd2,
    STATUS_INVALID  = 2'd3
  } status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] address;
    logic [31:0] entry_total;
    logic [63:0] fence_value;
    logic        resume_after;
    logic        probe_ok;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] fetch_address;
    logic [31:0] fetch_index;
    logic [31:0] batch_total;
    logic [63:0] fence_out;
    logic [2:0]  nest_depth;
    logic        in_jump;
    logic [63:0] return_address;
    logic        batch_done;
  } rsp_t;

  // One saved frame. below_base is the base of the frame underneath, so that
  // a pop learns the new top-of-stack address from the same read.
  typedef struct packed {
    logic [63:0] base;
    logic [31:0] index;
    logic [31:0] total;
    logic [63:0] fence;
    logic [63:0] below_base;
  } frame_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    frame_t            wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } frame_mem_req_t;

endpackage

`default_nettype wire

FILE: rtl/core/ibcs_frame_mem.sv
// ----------------------------------------------------------------------------
// ibcs_frame_mem
// Frame storage of the call stack: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ibcs_frame_mem
  import ibcs_pkg::*;
(
  input  wire logic           clk,
  input  wire frame_mem_req_t req,
  output frame_t              rd_data
);

  frame_t mem [NEST_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Read data holds between reads so a stalled consumer still sees it.
  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data <= mem[req.raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/indirect_buffer_call_stack.sv
// ----------------------------------------------------------------------------
// indirect_buffer_call_stack
// Command fetch pointer with an indirect-buffer call stack.
// ----------------------------------------------------------------------------
//
//   channel   dir   payload   handshake               per beat
//   -------   ---   -------   ---------------------   --------------------
//   cmd       in    cmd_t     cmd_valid / cmd_ready   one command
//   rsp       out   rsp_t     rsp_valid / rsp_ready   one result a command
//
// Each command takes two steps: the accept cycle, in which a return issues
// its read of the frame memory, and an execute cycle, in which the registered
// read data is used and the result is loaded into the output register.
// The execute cycle waits while the output register holds an untaken beat;
// a new command is accepted in the cycle after execute, even while the last
// result still waits. The synchronous reset clears the fetch pointer, depth,
// flags and handshake state; the frame memory has no reset and needs no
// clearing pass, since only data of pushed frames is ever used.
// ----------------------------------------------------------------------------
`default_nettype none

module indirect_buffer_call_stack
  import ibcs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  output logic      cmd_ready,
  input  wire cmd_t cmd,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output rsp_t      rsp
);

  // Control state.
  state_e state, state_next;
  cmd_t   cmd_reg;

  // Current fetch pointer.
  logic [63:0] cur_base,  cur_base_next;
  logic [31:0] cur_index, cur_index_next;
  logic [31:0] cur_total, cur_total_next;
  logic [63:0] cur_fence, cur_fence_next;

  // Stack bookkeeping. top_base mirrors the base of the top frame, or zero
  // when the stack is empty, so the result never waits on a memory read.
  logic [DEPTH_W-1:0] depth, depth_next;
  logic               jumping, jumping_next;
  logic               cont_flag, cont_flag_next;
  logic [63:0]        top_base, top_base_next;

  logic [1:0]     status;
  logic           cmd_fire;
  logic           exec_fire;
  logic           stack_full;
  logic           return_bad;
  frame_mem_req_t mem_req;
  frame_t         mem_rd;

  assign cmd_fire   = cmd_valid && cmd_ready;
  // The result can be loaded when the output register is empty or drains now.
  assign exec_fire  = (state == ST_EXEC) && (!rsp_valid || rsp_ready);
  assign stack_full = (depth == DEPTH_W'(NEST_DEPTH));
  assign return_bad = !jumping || (depth == '0);

  ibcs_frame_mem u_frame_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (mem_rd)
  );

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd_fire) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_fire) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // FSM outputs: accept only between commands; a return reads the top frame
  // during its accept cycle, so the data is waiting in the execute cycle.
  always_comb begin
    cmd_ready = 1'b0;
    case (state)
      ST_IDLE: cmd_ready = 1'b1;
      ST_EXEC: cmd_ready = 1'b0;
      default: cmd_ready = 1'b0;
    endcase
  end

  // Command execution.
  always_comb begin
    cur_base_next  = cur_base;
    cur_index_next = cur_index;
    cur_total_next = cur_total;
    cur_fence_next = cur_fence;
    depth_next     = depth;
    jumping_next   = jumping;
    cont_flag_next = cont_flag;
    top_base_next  = top_base;
    status         = STATUS_OK;

    mem_req.re          = cmd_fire && (cmd.op == OP_RETURN);
    mem_req.raddr       = ADDR_W'(depth - DEPTH_W'(1));
    mem_req.we          = 1'b0;
    mem_req.waddr       = ADDR_W'(depth);
    mem_req.wdata.base       = cur_base;
    mem_req.wdata.index      = cur_index;
    mem_req.wdata.total      = cur_total;
    mem_req.wdata.fence      = cur_fence;
    mem_req.wdata.below_base = top_base;

    case (cmd_reg.op)
      OP_SUBMIT: begin
        cur_base_next  = cmd_reg.address;
        cur_index_next = '0;
        cur_total_next = cmd_reg.entry_total;
        cur_fence_next = cmd_reg.fence_value;
      end
      OP_ADVANCE: begin
        if (cur_index != '1) begin
          cur_index_next = cur_index + 32'd1;
        end
      end
      OP_JUMP: begin
        // A failed probe takes precedence over a full stack.
        if (!cmd_reg.probe_ok) begin
          status = STATUS_FAULT;
        end else if (stack_full) begin
          status = STATUS_OVERFLOW;
        end else begin
          mem_req.we     = exec_fire;
          depth_next     = depth + DEPTH_W'(1);
          jumping_next   = 1'b1;
          cont_flag_next = cmd_reg.resume_after;
          top_base_next  = cur_base;
          cur_base_next  = cmd_reg.address;
          cur_index_next = '0;
          cur_total_next = cmd_reg.entry_total;
        end
      end
      OP_RETURN: begin
        if (return_bad) begin
          status = STATUS_INVALID;
        end else begin
          depth_next     = depth - DEPTH_W'(1);
          top_base_next  = mem_rd.below_base;
          cont_flag_next = 1'b0;
          if (cont_flag) begin
            cur_base_next  = mem_rd.base;
            cur_index_next = mem_rd.index;
            cur_total_next = mem_rd.total;
            cur_fence_next = mem_rd.fence;
          end
          if (depth == DEPTH_W'(1)) begin
            jumping_next = 1'b0;
          end
        end
      end
      default: status = STATUS_OK;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cur_base  <= '0;
      cur_index <= '0;
      cur_total <= '0;
      cur_fence <= '0;
      depth     <= '0;
      jumping   <= 1'b0;
      cont_flag <= 1'b0;
      top_base  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (exec_fire) begin
        cur_base  <= cur_base_next;
        cur_index <= cur_index_next;
        cur_total <= cur_total_next;
        cur_fence <= cur_fence_next;
        depth     <= depth_next;
        jumping   <= jumping_next;
        cont_flag <= cont_flag_next;
        top_base  <= top_base_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      cmd_reg <= cmd;
    end
    if (exec_fire) begin
      rsp.status         <= status;
      rsp.fetch_address  <= cur_base_next;
      rsp.fetch_index    <= cur_index_next;
      rsp.batch_total    <= cur_total_next;
      rsp.fence_out      <= cur_fence_next;
      rsp.nest_depth     <= 3'(depth_next);
      rsp.in_jump        <= jumping_next;
      rsp.return_address <= top_base_next;
      rsp.batch_done     <= (cur_index_next >= cur_total_next);
    end
  end

  // The depth never goes beyond the stack size.
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= DEPTH_W'(NEST_DEPTH))
    else $error("call stack depth beyond its size");

  // Executing inside an indirect buffer exactly when frames are stacked.
  a_jump_depth: assert property (@(posedge clk) disable iff (rst)
    jumping == (depth != '0))
    else $error("jump flag disagrees with stack depth");

  // An empty stack reports a zero return address.
  a_top_empty: assert property (@(posedge clk) disable iff (rst)
    (depth == '0) |-> (top_base == '0))
    else $error("return address not zero on empty stack");

  // An accepted command moves to execution in the next cycle.
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    cmd_fire |=> (state == ST_EXEC))
    else $error("accepted command did not reach execution");

  // A new result only appears out of an execute cycle.
  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == ST_EXEC))
    else $error("result beat without an executed command");

endmodule

`default_nettype wire
